// ===== rtl/kslex_pkg.sv =====
// Package: shared constants, codes and control/status types of the k-subset enumerator.
`timescale 1ns / 1ps

package kslex_pkg;

   localparam int MAX_ITEMS  = 16;
   localparam int VALUE_BITS = 32;
   localparam int POS_BITS   = $clog2(MAX_ITEMS);
   localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int SUM_BITS   = COUNT_BITS + 1;
   localparam int ACT_BITS   = 2;
   localparam int CSR_BITS   = 1;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_ADVANCE = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_BASE_COUNT  = 1'b0,
      CSR_SUBSET_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_EMIT_SLOT,
      ST_EMIT_PUT,
      ST_STATUS
   } ctrl_state_type;

   typedef struct packed {
      logic mem_wr;
      logic idx_clr;
      logic idx_last_ld;
      logic idx_inc;
      logic idx_dec;
      logic run_zero;
      logic run_from_slot;
      logic run_inc;
      logic slot_wr;
      logic done_set;
      logic done_clr;
      logic stat_ld;
      logic stat_exh;
      logic stat_err;
      logic rd_en;
      logic out_elem;
      logic out_stat;
   } dp_cmd_type;

   typedef struct packed {
      logic k_gt_n;
      logic k_zero;
      logic done;
      logic scan_hit;
      logic idx_first;
      logic idx_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/kslex_datapath.sv =====
// Datapath: config registers, slot positions, base table memory and result word register.
`timescale 1ns / 1ps

module kslex_datapath
   import kslex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  csr_valid,
   input  logic [CSR_BITS-1:0]   csr_index,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  logic [POS_BITS-1:0]   req_entry_index,
   input  logic [VALUE_BITS-1:0] req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_BITS-1:0]   rsp_position,
   output logic [VALUE_BITS-1:0] rsp_element,
   output logic                  rsp_has_element,
   output logic                  rsp_exhausted,
   output logic                  rsp_size_error,
   output logic                  rsp_last_of_run
);

   logic [COUNT_BITS-1:0] base_count_ff;
   logic [COUNT_BITS-1:0] subset_size_ff;
   logic [COUNT_BITS-1:0] n_eff;

   logic [POS_BITS-1:0]   idx_ff;
   logic [POS_BITS-1:0]   idx_in;
   logic [POS_BITS-1:0]   run_ff;
   logic [POS_BITS-1:0]   run_in;
   logic [POS_BITS-1:0]   slot_ff [MAX_ITEMS];
   logic [POS_BITS-1:0]   slot_rd;
   logic                  done_ff;
   logic                  stat_exh_ff;
   logic                  stat_err_ff;

   logic [VALUE_BITS-1:0] base_mem [MAX_ITEMS];
   logic [VALUE_BITS-1:0] elem_rd_ff;

   logic                  rsp_valid_ff;
   logic [POS_BITS-1:0]   rsp_position_ff;
   logic [VALUE_BITS-1:0] rsp_element_ff;
   logic                  rsp_has_element_ff;
   logic                  rsp_exhausted_ff;
   logic                  rsp_size_error_ff;
   logic                  rsp_last_of_run_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_count_ff  <= '0;
         subset_size_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_COUNT:  base_count_ff  <= csr_data;
            CSR_SUBSET_SIZE: subset_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign n_eff = (base_count_ff > COUNT_BITS'(MAX_ITEMS)) ? COUNT_BITS'(MAX_ITEMS)
                                                          : base_count_ff;
   assign slot_rd = slot_ff[idx_ff];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_last_ld) begin
         idx_in = POS_BITS'(subset_size_ff - COUNT_BITS'(1));
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + POS_BITS'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - POS_BITS'(1);
      end
      run_in = run_ff;
      if (cmd.run_zero) begin
         run_in = '0;
      end else if (cmd.run_from_slot) begin
         run_in = slot_rd + POS_BITS'(1);
      end else if (cmd.run_inc) begin
         run_in = run_ff + POS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         run_ff      <= '0;
         done_ff     <= 1'b0;
         stat_exh_ff <= 1'b0;
         stat_err_ff <= 1'b0;
         for (int i = 0; i < MAX_ITEMS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
         run_ff <= run_in;
         if (cmd.slot_wr) begin
            slot_ff[idx_ff] <= run_ff;
         end
         if (cmd.done_set) begin
            done_ff <= 1'b1;
         end else if (cmd.done_clr) begin
            done_ff <= 1'b0;
         end
         if (cmd.stat_ld) begin
            stat_exh_ff <= cmd.stat_exh;
            stat_err_ff <= cmd.stat_err;
         end
      end
   end

   // base table
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         base_mem[req_entry_index] <= req_entry_value;
      end
      if (cmd.rd_en) begin
         elem_rd_ff <= base_mem[slot_rd];
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_elem || cmd.out_stat) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_elem) begin
         rsp_position_ff    <= idx_ff;
         rsp_element_ff     <= elem_rd_ff;
         rsp_has_element_ff <= 1'b1;
         rsp_exhausted_ff   <= 1'b0;
         rsp_size_error_ff  <= 1'b0;
         rsp_last_of_run_ff <= stat.idx_last;
      end else if (cmd.out_stat) begin
         rsp_position_ff    <= '0;
         rsp_element_ff     <= '0;
         rsp_has_element_ff <= 1'b0;
         rsp_exhausted_ff   <= stat_exh_ff;
         rsp_size_error_ff  <= stat_err_ff;
         rsp_last_of_run_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_has_element = rsp_has_element_ff;
   assign rsp_exhausted   = rsp_exhausted_ff;
   assign rsp_size_error  = rsp_size_error_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;

   // slot s can still grow while pos + k < n + s
   assign stat.k_gt_n    = subset_size_ff > n_eff;
   assign stat.k_zero    = subset_size_ff == '0;
   assign stat.done      = done_ff;
   assign stat.scan_hit  = (SUM_BITS'(slot_rd) + SUM_BITS'(subset_size_ff))
                         < (SUM_BITS'(n_eff) + SUM_BITS'(idx_ff));
   assign stat.idx_first = idx_ff == '0;
   assign stat.idx_last  = (COUNT_BITS'(idx_ff) + COUNT_BITS'(1)) == subset_size_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_elem && cmd.out_stat))
      else $error("element and status word loaded together");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.slot_wr |-> (COUNT_BITS'(idx_ff) < subset_size_ff))
      else $error("slot write beyond subset size");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_element_ff) |-> rsp_last_of_run_ff)
      else $error("status word not marked last");

endmodule

// ===== rtl/kslex_ctrl.sv =====
// Controller: sequences load, restart, scan, refill and result emission.
`timescale 1ns / 1ps

module kslex_ctrl
   import kslex_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACT_BITS-1:0] req_action,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_LOAD: begin
                     cmd.mem_wr = 1'b1;
                  end
                  ACT_RESTART: begin
                     if (stat.k_gt_n) begin
                        cmd.done_set = 1'b1;
                        cmd.stat_ld  = 1'b1;
                        cmd.stat_err = 1'b1;
                        state_in     = ST_STATUS;
                     end else if (stat.k_zero) begin
                        cmd.done_clr = 1'b1;
                        cmd.stat_ld  = 1'b1;
                        state_in     = ST_STATUS;
                     end else begin
                        cmd.done_clr = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        cmd.run_zero = 1'b1;
                        state_in     = ST_FILL;
                     end
                  end
                  ACT_ADVANCE: begin
                     if (stat.done || stat.k_gt_n || stat.k_zero) begin
                        cmd.done_set = 1'b1;
                        cmd.stat_ld  = 1'b1;
                        cmd.stat_exh = 1'b1;
                        state_in     = ST_STATUS;
                     end else begin
                        cmd.idx_last_ld = 1'b1;
                        state_in        = ST_SCAN;
                     end
                  end
                  ACT_NOP: ;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_hit) begin
               cmd.run_from_slot = 1'b1;
               state_in          = ST_FILL;
            end else if (stat.idx_first) begin
               cmd.done_set = 1'b1;
               cmd.stat_ld  = 1'b1;
               cmd.stat_exh = 1'b1;
               state_in     = ST_STATUS;
            end else begin
               cmd.idx_dec = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.slot_wr = 1'b1;
            cmd.run_inc = 1'b1;
            if (stat.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_EMIT_SLOT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT_SLOT: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (stat.out_free) begin
               cmd.out_elem = 1'b1;
               if (stat.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_EMIT_SLOT;
               end
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.out_stat = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!stat.k_zero && !stat.k_gt_n))
      else $error("scan with empty or oversized subset");

   a_empty_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_action == ACT_ADVANCE && stat.k_zero)
      |=> (state_ff == ST_STATUS))
      else $error("advance on empty subset did not report exhausted");

   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_PUT && stat.out_free && stat.idx_last) |=> (state_ff == ST_IDLE))
      else $error("emission did not end on last slot");

endmodule

// ===== rtl/k_subset_lexicographic_enumerator_core.sv =====
// Top level: lexicographic k-subset enumerator over a loaded base table.
// Load writes one table entry. Restart refills the k slots, then emits one word per slot.
// Advance scans back for a slot that can grow, refills from it, then emits every slot.
// Status-only words flag a size error or exhaustion, or end an empty (k = 0) run.
// Synchronous active-high reset clears control, slot positions, done flag and registers;
// the base table holds no reset value and must be loaded before it is read.
`timescale 1ns / 1ps

module k_subset_lexicographic_enumerator_core
   import kslex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_BITS-1:0]   csr_index,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACT_BITS-1:0]   req_action,
   input  logic [POS_BITS-1:0]   req_entry_index,
   input  logic [VALUE_BITS-1:0] req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_BITS-1:0]   rsp_position,
   output logic [VALUE_BITS-1:0] rsp_element,
   output logic                  rsp_has_element,
   output logic                  rsp_exhausted,
   output logic                  rsp_size_error,
   output logic                  rsp_last_of_run
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   kslex_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   kslex_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_element     (rsp_element),
      .rsp_has_element (rsp_has_element),
      .rsp_exhausted   (rsp_exhausted),
      .rsp_size_error  (rsp_size_error),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== tb/sv/k_subset_lexicographic_enumerator_core_tb.sv =====
// Testbench: k-subset enumerator checked word by word against a built-in subset predictor.
`timescale 1ns / 1ps

module k_subset_lexicographic_enumerator_core_tb;
   import kslex_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      logic [POS_BITS-1:0]   position;
      logic [VALUE_BITS-1:0] element;
      logic                  has_element;
      logic                  exhausted;
      logic                  size_error;
      logic                  last_of_run;
   } subset_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_BASE_COUNT;
   logic [COUNT_BITS-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACT_BITS-1:0]   req_action = ACT_NOP;
   logic [POS_BITS-1:0]   req_entry_index = '0;
   logic [VALUE_BITS-1:0] req_entry_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [POS_BITS-1:0]   rsp_position;
   logic [VALUE_BITS-1:0] rsp_element;
   logic                  rsp_has_element;
   logic                  rsp_exhausted;
   logic                  rsp_size_error;
   logic                  rsp_last_of_run;

   k_subset_lexicographic_enumerator_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_element     (rsp_element),
      .rsp_has_element (rsp_has_element),
      .rsp_exhausted   (rsp_exhausted),
      .rsp_size_error  (rsp_size_error),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [VALUE_BITS-1:0] base_image [MAX_ITEMS];
   int unsigned           slot_image [MAX_ITEMS];
   bit                    walk_done = 1'b0;
   int unsigned           count_reg = 0;
   int unsigned           size_reg = 0;
   subset_word_type       expected_words [$];
   int                    mismatch_count = 0;

   bit tx_idling = 1'b1;
   bit rx_idling = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int cycle_count = 0;

   initial begin
      for (int i = 0; i < MAX_ITEMS; i++) slot_image[i] = 0;
   end

   function automatic void queue_word(int unsigned pos, logic [VALUE_BITS-1:0] elem,
                                      bit has, bit exh, bit err, bit last);
      subset_word_type w;
      w.position    = POS_BITS'(pos);
      w.element     = elem;
      w.has_element = has;
      w.exhausted   = exh;
      w.size_error  = err;
      w.last_of_run = last;
      expected_words = {expected_words, w};
   endfunction

   function automatic void queue_subset();
      int unsigned p;
      if (size_reg == 0) begin
         queue_word(0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
      end else begin
         for (int unsigned i = 0; i < size_reg; i++) begin
            p = slot_image[i];
            queue_word(i, (p < MAX_ITEMS) ? base_image[p] : '0, 1'b1, 1'b0, 1'b0,
                       i + 1 == size_reg);
         end
      end
   endfunction

   function automatic void predict_subsets(action_type act, logic [POS_BITS-1:0] idx,
                                           logic [VALUE_BITS-1:0] val);
      int unsigned n;
      int unsigned k;
      bit grown;
      n = (count_reg > MAX_ITEMS) ? MAX_ITEMS : count_reg;
      k = size_reg;
      grown = 1'b0;
      case (act)
         ACT_LOAD: base_image[idx] = val;
         ACT_RESTART: begin
            if (k > n) begin
               walk_done = 1'b1;
               queue_word(0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
               for (int unsigned i = 0; i < k; i++) slot_image[i] = i;
               walk_done = 1'b0;
               queue_subset();
            end
         end
         ACT_ADVANCE: begin
            if (!walk_done && k <= n) begin
               for (int s = int'(k) - 1; s >= 0 && !grown; s--) begin
                  if (slot_image[s] + k < n + s) begin
                     slot_image[s] = slot_image[s] + 1;
                     for (int j = s + 1; j < int'(k); j++)
                        slot_image[j] = slot_image[j-1] + 1;
                     grown = 1'b1;
                  end
               end
            end
            if (grown) begin
               queue_subset();
            end else begin
               walk_done = 1'b1;
               queue_word(0, '0, 1'b0, 1'b1, 1'b0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // result side: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      subset_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: pos=%0d elem=%h has=%b exh=%b err=%b last=%b",
                        rsp_position, rsp_element, rsp_has_element, rsp_exhausted,
                        rsp_size_error, rsp_last_of_run);
         end else begin
            want = expected_words.pop_front();
            if ({rsp_position, rsp_element, rsp_has_element, rsp_exhausted,
                 rsp_size_error, rsp_last_of_run} !==
                {want.position, want.element, want.has_element, want.exhausted,
                 want.size_error, want.last_of_run}) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp pos=%0d elem=%h has=%b exh=%b err=%b last=%b",
                           want.position, want.element, want.has_element,
                           want.exhausted, want.size_error, want.last_of_run);
                  $display("          got pos=%0d elem=%h has=%b exh=%b err=%b last=%b",
                           rsp_position, rsp_element, rsp_has_element, rsp_exhausted,
                           rsp_size_error, rsp_last_of_run);
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL k_subset_lexicographic_enumerator_core");
      $finish;
   end

   task automatic send_word(action_type act, logic [POS_BITS-1:0] idx,
                            logic [VALUE_BITS-1:0] val);
      int gap;
      gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_subsets(act, idx, val);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= COUNT_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_BASE_COUNT) count_reg = value & 31;
      else size_reg = value & 31;
   endtask

   task automatic configure(int unsigned n, int unsigned k);
      wait_drained();
      write_reg(CSR_BASE_COUNT, n);
      write_reg(CSR_SUBSET_SIZE, k);
      csr_valid <= 1'b0;
   endtask

   // k = 0 needs no table, so it runs before any load
   task automatic test_empty_subset();
      configure(0, 0);
      send_word(ACT_RESTART, '0, '0);
      send_word(ACT_ADVANCE, '0, '0);
      send_word(ACT_NOP, '1, '1);
   endtask

   task automatic test_table_load();
      logic [VALUE_BITS-1:0] v;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         v = (i == 0) ? '0 : (i == MAX_ITEMS - 1) ? '1 : VALUE_BITS'($urandom);
         send_word(ACT_LOAD, POS_BITS'(i), v);
      end
   endtask

   task automatic test_size_error();
      configure(3, 5);
      send_word(ACT_RESTART, '0, '0);
      send_word(ACT_ADVANCE, '0, '0);
   endtask

   task automatic test_full_walk();
      configure(16, 16);
      send_word(ACT_RESTART, '0, '0);
      send_word(ACT_ADVANCE, '0, '0);
      configure(3, 2);
      send_word(ACT_RESTART, '0, '0);
      repeat (3) send_word(ACT_ADVANCE, '0, '0);
   endtask

   task automatic test_saturated_count();
      configure(31, 31);
      send_word(ACT_RESTART, '0, '0);
      configure(20, 16);
      send_word(ACT_RESTART, '0, '0);
   endtask

   task automatic test_stale_positions();
      configure(6, 3);
      send_word(ACT_ADVANCE, '0, '0);
      configure(8, 5);
      send_word(ACT_ADVANCE, '0, '0);
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      bit saved;
      saved = tx_idling;
      tx_idling = 1'b0;
      configure(10, 4);
      hold_request = 1'b1;
      send_word(ACT_RESTART, '0, '0);
      repeat (20) send_word(ACT_ADVANCE, '0, '0);
      tx_idling = saved;
      wait_drained();
   endtask

   task automatic test_random_walks();
      int unsigned n;
      int unsigned k;
      int unsigned r;
      int sent;
      sent = 0;
      while (sent < 360) begin
         r = $urandom_range(0, 9);
         if (r < 5) n = $urandom_range(1, 6);
         else if (r < 9) n = $urandom_range(0, 16);
         else n = $urandom_range(17, 31);
         r = $urandom_range(0, 9);
         if (r < 6) k = $urandom_range(0, (n > 4) ? 4 : n);
         else if (r < 8) k = $urandom_range(0, (n > 16) ? 16 : n);
         else k = $urandom_range(0, 31);
         configure(n, k);
         if ($urandom_range(0, 3) != 0) begin
            send_word(ACT_RESTART, '0, '0);
            sent++;
         end
         repeat ($urandom_range(2, 16)) begin
            r = $urandom_range(0, 19);
            if (r < 15) begin
               send_word(ACT_ADVANCE, POS_BITS'($urandom), VALUE_BITS'($urandom));
               sent++;
            end else if (r < 17) begin
               send_word(ACT_LOAD, POS_BITS'($urandom_range(0, MAX_ITEMS - 1)),
                         VALUE_BITS'($urandom));
               sent++;
            end else if (r < 19) begin
               send_word(ACT_RESTART, POS_BITS'($urandom), VALUE_BITS'($urandom));
               sent++;
            end else begin
               send_word(ACT_NOP, POS_BITS'($urandom), VALUE_BITS'($urandom));
            end
         end
      end
   endtask

   // no idling on either side from here on
   task automatic test_steady_stream();
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      configure(5, 3);
      send_word(ACT_RESTART, '0, '0);
      repeat (12) send_word(ACT_ADVANCE, '0, '0);
      configure(16, 2);
      send_word(ACT_RESTART, '0, '0);
      repeat (20) send_word(ACT_ADVANCE, '0, '0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_subset();
      test_table_load();
      test_size_error();
      test_full_walk();
      test_saturated_count();
      test_stale_positions();
      test_backpressure();
      test_random_walks();
      test_steady_stream();
      wait_drained();
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("PASS k_subset_lexicographic_enumerator_core");
      else
         $display("FAIL k_subset_lexicographic_enumerator_core");
      $finish;
   end

endmodule
